// ----- design/snst_pkg.sv -----
// ----------------------------------------------------------------------------
// snst_pkg
// Shared constants and types for the segment near sphere test pipeline.
// ----------------------------------------------------------------------------
package snst_pkg;

  // default coordinate width, one common length unit
  localparam int COORD_BITS_DEF = 24;

  // configuration register index width
  localparam int CFG_ADDR_W = 2;

  // configuration register map
  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_CENTER_X = 2'd0,
    CFG_CENTER_Y = 2'd1,
    CFG_CENTER_Z = 2'd2,
    CFG_SPREAD   = 2'd3
  } cfg_reg_t;

  // per-item case decision carried down the pipeline next to the wide products
  typedef struct packed {
    logic ep;       // closest point is an endpoint (or segment has zero length)
    logic ep_near;  // endpoint distance squared below the limit
  } sel_t;

endpackage

// ----- design/segment_near_sphere_test.sv -----
// ----------------------------------------------------------------------------
// segment_near_sphere_test
// Decides whether a 3D segment passes closer than three spreads to a center.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one segment per transaction:
//   signed start and end coordinates. Result channel (out_valid/out_ready)
//   returns one is_near bit per segment, in input order.
//   Configuration: write center_x/y/z and spread through cfg_we, cfg_addr,
//   cfg_wdata while no segment is in flight. The squared limit 9*spread^2 is
//   rebuilt through sg2_r and then lim_r after a spread write.
//   Stages: a segment passes diffs, products, sums, case decision plus
//   partial products, product sums and final compare, then shows its
//   result on out_valid.
//   Throughput: one segment per cycle while out_ready does not stall the
//   pipeline; the wide products are split into four half-width partial
//   products in one stage and their sum in the next.
//   Reset (rst_n low, synchronous) empties the pipeline and clears the
//   configuration registers to zero.
//   When the receiver holds out_ready low with a result waiting, the whole
//   pipeline freezes and in_ready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module segment_near_sphere_test
  import snst_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // segment input
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] in_start_x,
  input  logic signed [COORD_BITS-1:0] in_start_y,
  input  logic signed [COORD_BITS-1:0] in_start_z,
  input  logic signed [COORD_BITS-1:0] in_end_x,
  input  logic signed [COORD_BITS-1:0] in_end_y,
  input  logic signed [COORD_BITS-1:0] in_end_z,
  // result output
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_is_near,
  // configuration write port
  input  logic                         cfg_we,
  input  logic [CFG_ADDR_W-1:0]        cfg_addr,
  input  logic [COORD_BITS-1:0]        cfg_wdata
);

  localparam int W    = COORD_BITS;
  localparam int DW   = W + 1;        // coordinate difference
  localparam int SW   = 2 * W + 2;    // squares, sums of squares, limit
  localparam int RDW  = 2 * W + 3;    // signed dot product
  localparam int FW   = 2 * SW;       // full wide product
  localparam int SUMW = FW + 1;       // sum of two wide products
  localparam int GW   = 2 * (W - 1);  // spread squared

  function automatic logic signed [DW-1:0] sdiff(input logic signed [W-1:0] a,
                                                 input logic signed [W-1:0] b);
    sdiff = DW'(a) - DW'(b);
  endfunction

  // pipeline control
  logic en;
  logic v1_r, v2_r, v3_r, v4_r, v5_r, out_valid_r;

  assign en        = !out_valid_r || out_ready;
  assign in_ready  = en;
  assign out_valid = out_valid_r;

  // configuration registers
  logic signed [W-1:0] center_x_r, center_y_r, center_z_r;
  logic [W-2:0]        spread_r;
  logic [GW-1:0]       sg2_r;
  logic [SW-1:0]       lim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r <= '0;
      center_y_r <= '0;
      center_z_r <= '0;
      spread_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        CFG_CENTER_X: center_x_r <= cfg_wdata;
        CFG_CENTER_Y: center_y_r <= cfg_wdata;
        CFG_CENTER_Z: center_z_r <= cfg_wdata;
        CFG_SPREAD:   spread_r   <= cfg_wdata[W-2:0];
        default: ;
      endcase
    end
  end

  // squared limit (3*spread)^2 = 9*spread^2, multiply then shift-add
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sg2_r <= '0;
      lim_r <= '0;
    end else begin
      sg2_r <= GW'(spread_r * spread_r);
      lim_r <= (SW'(sg2_r) << 3) + SW'(sg2_r);
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r        <= in_valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      v5_r        <= v4_r;
      out_valid_r <= v5_r;
    end
  end

  // stage 1: rc = c - s, d = e - s, q = c - e
  logic signed [DW-1:0] r_r [3];
  logic signed [DW-1:0] d_r [3];
  logic signed [DW-1:0] q_r [3];
  logic signed [DW-1:0] r_nxt [3];
  logic signed [DW-1:0] d_nxt [3];
  logic signed [DW-1:0] q_nxt [3];

  always_comb begin
    r_nxt[0] = sdiff(center_x_r, in_start_x);
    r_nxt[1] = sdiff(center_y_r, in_start_y);
    r_nxt[2] = sdiff(center_z_r, in_start_z);
    d_nxt[0] = sdiff(in_end_x, in_start_x);
    d_nxt[1] = sdiff(in_end_y, in_start_y);
    d_nxt[2] = sdiff(in_end_z, in_start_z);
    q_nxt[0] = sdiff(center_x_r, in_end_x);
    q_nxt[1] = sdiff(center_y_r, in_end_y);
    q_nxt[2] = sdiff(center_z_r, in_end_z);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_r <= r_nxt;
      d_r <= d_nxt;
      q_r <= q_nxt;
    end
  end

  // stage 2: per-axis products
  logic signed [SW-1:0] prr_r [3];
  logic signed [SW-1:0] pdd_r [3];
  logic signed [SW-1:0] prd_r [3];
  logic signed [SW-1:0] pqq_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        prr_r[i] <= SW'(r_r[i] * r_r[i]);
        pdd_r[i] <= SW'(d_r[i] * d_r[i]);
        prd_r[i] <= SW'(r_r[i] * d_r[i]);
        pqq_r[i] <= SW'(q_r[i] * q_r[i]);
      end
    end
  end

  // stage 3: |rc|^2, |d|^2, rc.d, |c-e|^2
  logic [SW-1:0]         rr_r, dd_r, qq_r;
  logic [SW-1:0]         rr_nxt, dd_nxt, qq_nxt;
  logic signed [RDW-1:0] rd_r, rd_nxt;

  always_comb begin
    rr_nxt = $unsigned(prr_r[0]) + $unsigned(prr_r[1]) + $unsigned(prr_r[2]);
    dd_nxt = $unsigned(pdd_r[0]) + $unsigned(pdd_r[1]) + $unsigned(pdd_r[2]);
    qq_nxt = $unsigned(pqq_r[0]) + $unsigned(pqq_r[1]) + $unsigned(pqq_r[2]);
    rd_nxt = RDW'(prd_r[0]) + RDW'(prd_r[1]) + RDW'(prd_r[2]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rr_r <= rr_nxt;
      dd_r <= dd_nxt;
      qq_r <= qq_nxt;
      rd_r <= rd_nxt;
    end
  end

  // stage 4: pick the closest-point case, endpoint compares
  logic start_side, end_side;
  sel_t sel_nxt, sel4_r, sel5_r;

  always_comb begin
    start_side      = (dd_r == '0) || rd_r[RDW-1] || (rd_r == '0);
    end_side        = rd_r >= $signed({1'b0, dd_r});
    sel_nxt.ep      = start_side || end_side;
    sel_nxt.ep_near = start_side ? (rr_r < lim_r) : (qq_r < lim_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sel4_r <= sel_nxt;
      sel5_r <= sel4_r;
    end
  end

  // stages 4-5: interior case products |rc|^2*|d|^2, lim*|d|^2, (rc.d)^2
  logic [FW-1:0] p_rrdd, p_limdd, p_rdrd;

  snst_wide_mul #(.AW(SW)) u_mul_rrdd (
    .clk (clk),
    .en  (en),
    .a   (rr_r),
    .b   (dd_r),
    .p   (p_rrdd)
  );

  snst_wide_mul #(.AW(SW)) u_mul_limdd (
    .clk (clk),
    .en  (en),
    .a   (lim_r),
    .b   (dd_r),
    .p   (p_limdd)
  );

  // only used when 0 < rc.d < |d|^2, so the low bits hold the full value
  snst_wide_mul #(.AW(SW)) u_mul_rdrd (
    .clk (clk),
    .en  (en),
    .a   (rd_r[SW-1:0]),
    .b   (rd_r[SW-1:0]),
    .p   (p_rdrd)
  );

  // stage 6: interior compare and final select
  logic [SUMW-1:0] rhs;
  logic            near_int;
  logic            out_is_near_r, out_is_near_nxt;

  always_comb begin
    rhs             = SUMW'(p_limdd) + SUMW'(p_rdrd);
    near_int        = SUMW'(p_rrdd) < rhs;
    out_is_near_nxt = sel5_r.ep ? sel5_r.ep_near : near_int;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_is_near_r <= out_is_near_nxt;
    end
  end

  assign out_is_near = out_is_near_r;

  // checks on pipeline control
  a_stall_only_on_backpressure : assert property (
    @(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid_r && !out_ready)
  ) else $error("input stalled without output backpressure");

  a_last_stage_reaches_output : assert property (
    @(posedge clk) disable iff (!rst_n)
    (en && v5_r) |=> out_valid_r
  ) else $error("transaction lost before output register");

  a_output_has_source : assert property (
    @(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(v5_r)
  ) else $error("result appeared without a transaction in flight");

  a_frozen_pipeline_holds : assert property (
    @(posedge clk) disable iff (!rst_n)
    !en |=> ($stable(v5_r) && $stable(v4_r) && $stable(sel5_r))
  ) else $error("pipeline moved while stalled");

endmodule

// ----- design/snst_wide_mul.sv -----
// ----------------------------------------------------------------------------
// snst_wide_mul
// Two-stage unsigned multiplier: four half-width partial products, then a sum.
// ----------------------------------------------------------------------------
module snst_wide_mul #(
  parameter int AW = 50
) (
  input  logic            clk,
  input  logic            en,
  input  logic [AW-1:0]   a,
  input  logic [AW-1:0]   b,
  output logic [2*AW-1:0] p
);

  localparam int HW = AW / 2;
  localparam int LW = AW - HW;

  logic [AW-1:0]   pp_ll_r, pp_lh_r, pp_hl_r, pp_hh_r;
  logic [AW-1:0]   pp_ll_nxt, pp_lh_nxt, pp_hl_nxt, pp_hh_nxt;
  logic [AW:0]     mid;
  logic [2*AW-1:0] p_r, p_nxt;

  // partial products of the low and high halves
  always_comb begin
    pp_ll_nxt = AW'(a[LW-1:0] * b[LW-1:0]);
    pp_lh_nxt = AW'(a[LW-1:0] * b[AW-1:LW]);
    pp_hl_nxt = AW'(a[AW-1:LW] * b[LW-1:0]);
    pp_hh_nxt = AW'(a[AW-1:LW] * b[AW-1:LW]);
  end

  // recombine: hh at 2*LW, cross terms at LW, ll at 0
  always_comb begin
    mid   = (AW+1)'(pp_lh_r) + (AW+1)'(pp_hl_r);
    p_nxt = ((2*AW)'(pp_hh_r) << (2*LW)) + (2*AW)'(pp_ll_r)
          + ((2*AW)'(mid) << LW);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pp_ll_r <= pp_ll_nxt;
      pp_lh_r <= pp_lh_nxt;
      pp_hl_r <= pp_hl_nxt;
      pp_hh_r <= pp_hh_nxt;
      p_r     <= p_nxt;
    end
  end

  assign p = p_r;

endmodule

// ----- tb/segment_near_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_near_checker
// Watches the segment and result channels of segment_near_sphere_test, keeps
// its own copy of the center and spread registers from the write port, works
// out the expected is_near bit for each accepted segment and compares it with
// each accepted result, oldest first. Reports mismatches and counts failures.
// ----------------------------------------------------------------------------
module segment_near_checker
  import snst_pkg::*;
#(
  parameter int CW = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [CW-1:0]         in_start_x,
  input  logic [CW-1:0]         in_start_y,
  input  logic [CW-1:0]         in_start_z,
  input  logic [CW-1:0]         in_end_x,
  input  logic [CW-1:0]         in_end_y,
  input  logic [CW-1:0]         in_end_z,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic                  out_is_near,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CW-1:0]         cfg_wdata,
  output int                    fail_count,
  output int                    outstanding
);

  // local copy of the configuration
  logic signed [CW-1:0] ctr_x, ctr_y, ctr_z;
  logic [CW-2:0]        spread_val;

  // is_near bits still owed by the block, oldest first
  logic near_q[$];

  // exact squared-distance test of segment s..e against the center
  function automatic logic segment_is_near(
    input logic signed [CW-1:0] sx, sy, sz, ex, ey, ez,
    input logic signed [CW-1:0] cx, cy, cz,
    input logic [CW-2:0]        sg
  );
    longint          rx, ry, rz, dx, dy, dz, qx, qy, qz, rd;
    longint unsigned rr, dd, qq, lim;
    logic [127:0]    lhs, rhs, rd_w;
    rx = cx - sx;
    ry = cy - sy;
    rz = cz - sz;
    dx = ex - sx;
    dy = ey - sy;
    dz = ez - sz;
    rr = rx * rx + ry * ry + rz * rz;
    dd = dx * dx + dy * dy + dz * dz;
    rd = rx * dx + ry * dy + rz * dz;
    lim = 64'(sg) * 64'(sg) * 64'd9;
    // closest point is the start, or the segment is a point
    if (dd == 0 || rd <= 0)
      return rr < lim;
    // closest point is the end
    if (rd >= longint'(dd)) begin
      qx = cx - ex;
      qy = cy - ey;
      qz = cz - ez;
      qq = qx * qx + qy * qy + qz * qz;
      return qq < lim;
    end
    // interior: rr*dd - rd^2 < lim*dd, kept free of subtraction
    lhs = rr;
    lhs = lhs * dd;
    rhs = lim;
    rhs = rhs * dd;
    rd_w = rd;
    rhs = rhs + rd_w * rd_w;
    return lhs < rhs;
  endfunction

  always @(posedge clk) begin
    logic exp_near;
    if (!rst_n) begin
      ctr_x = '0;
      ctr_y = '0;
      ctr_z = '0;
      spread_val = '0;
      near_q.delete();
      fail_count <= 0;
      outstanding <= 0;
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_addr)
          CFG_CENTER_X: ctr_x = cfg_wdata;
          CFG_CENTER_Y: ctr_y = cfg_wdata;
          CFG_CENTER_Z: ctr_z = cfg_wdata;
          CFG_SPREAD:   spread_val = cfg_wdata[CW-2:0];
          default: ;
        endcase
      end
      // result transaction against the oldest expectation
      if (out_valid && out_ready) begin
        if (near_q.size() == 0) begin
          $display("%0t: is_near result with nothing pending, expected none, got %0b",
                   $time, out_is_near);
          fail_count <= fail_count + 1;
        end else begin
          exp_near = near_q.pop_front();
          if (out_is_near !== exp_near) begin
            $display("%0t: is_near mismatch, expected %0b, got %0b",
                     $time, exp_near, out_is_near);
            fail_count <= fail_count + 1;
          end
        end
      end
      // segment transaction
      if (in_valid && in_ready)
        near_q.push_back(segment_is_near(in_start_x, in_start_y, in_start_z,
                                         in_end_x, in_end_y, in_end_z,
                                         ctr_x, ctr_y, ctr_z, spread_val));
      outstanding <= near_q.size();
    end
  end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus for segment_near_sphere_test: a directed set of distance corner
// cases (endpoint, foot-point and perpendicular boundaries, zero-length and
// extreme segments) followed by random phases with fresh center and spread
// settings, random gaps on the segment side and random stalls on the result
// side. Checking is done by segment_near_checker.
// ----------------------------------------------------------------------------
module testbench;
  import snst_pkg::*;

  localparam int CW = COORD_BITS_DEF;
  localparam int C_MIN = -(1 << (CW - 1));
  localparam int C_MAX = (1 << (CW - 1)) - 1;

  typedef struct packed {
    logic [CW-1:0] sx, sy, sz, ex, ey, ez;
  } seg_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [CW-1:0]         in_start_x = '0;
  logic [CW-1:0]         in_start_y = '0;
  logic [CW-1:0]         in_start_z = '0;
  logic [CW-1:0]         in_end_x = '0;
  logic [CW-1:0]         in_end_y = '0;
  logic [CW-1:0]         in_end_z = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  out_is_near;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CW-1:0]         cfg_wdata = '0;

  int fail_count;
  int outstanding;

  // stimulus shaping: current center and spread, idle-free stretches
  int   ctr_x = 0, ctr_y = 0, ctr_z = 0, geo_scale = 0;
  logic tx_eager = 1'b0;
  logic rx_eager = 1'b0;
  int   stall_left = 0;

  segment_near_sphere_test #(.COORD_BITS(CW)) DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_start_x  (in_start_x),
    .in_start_y  (in_start_y),
    .in_start_z  (in_start_z),
    .in_end_x    (in_end_x),
    .in_end_y    (in_end_y),
    .in_end_z    (in_end_z),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_is_near (out_is_near),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata)
  );

  segment_near_checker #(.CW(CW)) u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_start_x  (in_start_x),
    .in_start_y  (in_start_y),
    .in_start_z  (in_start_z),
    .in_end_x    (in_end_x),
    .in_end_y    (in_end_y),
    .in_end_z    (in_end_z),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_is_near (out_is_near),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // result side backpressure: mostly ready, short and long stalls
  always @(posedge clk) begin
    int roll;
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_ready <= 1'b0;
    end else if (rx_eager) begin
      out_ready <= 1'b1;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 65) begin
        out_ready <= 1'b1;
      end else begin
        stall_left = (roll < 93) ? $urandom_range(0, 2) : $urandom_range(8, 40);
        out_ready <= 1'b0;
      end
    end
  end

  function automatic logic [CW-1:0] clamp_coord(input int v);
    if (v < C_MIN) return CW'(C_MIN);
    if (v > C_MAX) return CW'(C_MAX);
    return CW'(v);
  endfunction

  function automatic seg_t mk_segment(input int sx, sy, sz, ex, ey, ez);
    seg_t s;
    s.sx = clamp_coord(sx);
    s.sy = clamp_coord(sy);
    s.sz = clamp_coord(sz);
    s.ex = clamp_coord(ex);
    s.ey = clamp_coord(ey);
    s.ez = clamp_coord(ez);
    return s;
  endfunction

  // signed value of random magnitude, extremes now and then
  function automatic int rand_coord();
    int roll, n;
    roll = $urandom_range(0, 99);
    n = $urandom_range(1, CW);
    if (roll < 10) return C_MIN;
    if (roll < 20) return C_MAX;
    return int'($urandom_range(0, (1 << n) - 1)) - (1 << (n - 1));
  endfunction

  // offset within k spreads around the center
  function automatic int offset(input int k);
    int r;
    r = k * ((geo_scale > 0) ? geo_scale : 1);
    return int'($urandom_range(0, 2 * r)) - r;
  endfunction

  function automatic seg_t rand_segment();
    seg_t s;
    int roll, ax, ay, az;
    roll = $urandom_range(0, 99);
    ax = offset(8);
    ay = offset(8);
    az = offset(8);
    if (roll < 12) begin
      // raw bit noise
      s.sx = CW'($urandom);
      s.sy = CW'($urandom);
      s.sz = CW'($urandom);
      s.ex = CW'($urandom);
      s.ey = CW'($urandom);
      s.ez = CW'($urandom);
    end else if (roll < 22) begin
      // zero-length segment near the center
      s = mk_segment(ctr_x + offset(4), ctr_y + offset(4), ctr_z + offset(4), 0, 0, 0);
      s.ex = s.sx;
      s.ey = s.sy;
      s.ez = s.sz;
    end else if (roll < 55) begin
      // segment crossing the center region, mostly interior closest point
      s = mk_segment(ctr_x + ax, ctr_y + ay, ctr_z + az,
                     ctr_x - ax + offset(3), ctr_y - ay + offset(3),
                     ctr_z - az + offset(3));
    end else if (roll < 85) begin
      // both ends scattered around the center
      s = mk_segment(ctr_x + offset(5), ctr_y + offset(5), ctr_z + offset(5),
                     ctr_x + offset(5), ctr_y + offset(5), ctr_z + offset(5));
    end else begin
      s = mk_segment(rand_coord(), rand_coord(), rand_coord(),
                     rand_coord(), rand_coord(), rand_coord());
    end
    return s;
  endfunction

  // sender gap length: mostly none, some short, a few long
  function automatic int pick_gap();
    int roll;
    if (tx_eager) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  task automatic send_segment(input seg_t s);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_start_x <= s.sx;
    in_start_y <= s.sy;
    in_start_z <= s.sz;
    in_end_x   <= s.ex;
    in_end_y   <= s.ey;
    in_end_z   <= s.ez;
    do @(posedge clk); while (!in_ready);
  endtask

  // hold off new segments until every pending result is back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // new center and spread, written with the pipeline empty; spread first
  task automatic apply_settings(input int cx, cy, cz, input logic [CW-1:0] sp_word);
    drain_results();
    write_reg(CFG_SPREAD, sp_word);
    write_reg(CFG_CENTER_X, CW'(cx));
    write_reg(CFG_CENTER_Y, CW'(cy));
    write_reg(CFG_CENTER_Z, CW'(cz));
    cfg_we <= 1'b0;
    ctr_x = cx;
    ctr_y = cy;
    ctr_z = cz;
    geo_scale = int'(sp_word[CW-2:0]);
  endtask

  initial begin
    int               bits, pause_at;
    logic [CW-1:0]    sp_word;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: zero spread, nothing is near
    send_segment(mk_segment(0, 0, 0, 0, 0, 0));
    send_segment(mk_segment(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX));
    send_segment(mk_segment(C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN));

    // unit spread at the origin: limit of 3 exactly
    apply_settings(0, 0, 0, CW'(1));
    send_segment(mk_segment(3, 0, 0, 10, 0, 0));     // start closest, at the limit
    send_segment(mk_segment(2, 2, 0, 9, 0, 0));      // start closest, just inside
    send_segment(mk_segment(-10, 0, 0, -3, 0, 0));   // end closest, at the limit
    send_segment(mk_segment(-6, 2, 0, 0, 2, 0));     // foot point on the end
    send_segment(mk_segment(0, 2, 0, 5, 2, 0));      // foot point on the start
    send_segment(mk_segment(-5, 3, 0, 5, 3, 0));     // interior, at the limit
    send_segment(mk_segment(-5, 2, 2, 5, 2, 2));     // interior, just inside
    send_segment(mk_segment(1, 1, 1, 1, 1, 1));      // point, inside
    send_segment(mk_segment(3, 0, 0, 3, 0, 0));      // point, at the limit

    // extreme center and largest spread
    apply_settings(C_MIN, C_MIN, C_MIN, CW'(C_MAX));
    send_segment(mk_segment(C_MAX, C_MAX, C_MAX, C_MAX, C_MIN, C_MAX));
    send_segment(mk_segment(C_MAX, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX));
    send_segment(mk_segment(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN));

    // top spread bit alone is outside the register, spread stays zero
    apply_settings(C_MAX, C_MAX, C_MAX, {1'b1, {(CW-1){1'b0}}});
    send_segment(mk_segment(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX));
    send_segment(mk_segment(C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX));

    // random phases, each with its own settings
    for (int ph = 0; ph < 12; ph++) begin
      bits = $urandom_range(0, CW - 1);
      sp_word = CW'($urandom_range(0, (1 << bits) - 1));
      if ($urandom_range(0, 9) == 0) sp_word = CW'(C_MAX);
      sp_word[CW-1] = 1'($urandom_range(0, 1));
      apply_settings(rand_coord(), rand_coord(), rand_coord(), sp_word);
      tx_eager <= ($urandom_range(0, 3) == 0);
      rx_eager <= ($urandom_range(0, 3) == 0);
      pause_at = $urandom_range(10, 115);
      for (int i = 0; i < 125; i++) begin
        if (ph % 3 == 1 && i == pause_at) drain_results();
        send_segment(rand_segment());
      end
    end

    drain_results();
    repeat (12) @(posedge clk);
    if (fail_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ----- filelist.f -----
design/snst_pkg.sv
design/snst_wide_mul.sv
design/segment_near_sphere_test.sv
tb/segment_near_checker.sv
tb/testbench.sv
